@@ rtl/resp_command_parser_core_assert.svh @@
// Assertion macros for the RESP command parser.
// Included by the top level; needs nothing else.
`ifndef RESP_COMMAND_PARSER_CORE_ASSERT_SVH
`define RESP_COMMAND_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resp parser check failed");

// Next-cycle implication, disabled while reset is held.
`define RCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resp parser check failed");

`endif

@@ rtl/rcp_pkg.sv @@
// Shared types, codes and constants of the RESP command parser.
// Used by rcp_dec_acc and resp_command_parser_core; depends on nothing.
`default_nettype none

package rcp_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_STAR,
        PH_AHDR,
        PH_AHDR_CR,
        PH_DOLLAR,
        PH_BHDR,
        PH_BHDR_CR,
        PH_BODY,
        PH_BODY_CR,
        PH_BODY_LF
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    // Command codes.
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_PING   = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_GET    = 3'd3;
    localparam logic [2:0] CMD_DEL    = 3'd4;
    localparam logic [2:0] CMD_EXISTS = 3'd5;
    localparam logic [2:0] CMD_EXPIRE = 3'd6;
    localparam logic [2:0] CMD_TTL    = 3'd7;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_ARITY     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_BAD_INT   = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_KEY    = 3'd0;
    localparam logic [2:0] CFG_MAX_BULK   = 3'd1;
    localparam logic [2:0] CFG_MAX_ELEM   = 3'd2;
    localparam logic [2:0] CFG_MAX_DIGITS = 3'd3;

    // Reset values of the configuration registers.
    localparam logic [20:0] RST_MAX_KEY    = 21'd512;
    localparam logic [20:0] RST_MAX_BULK   = 21'd1048576;
    localparam logic [1:0]  RST_MAX_ELEM   = 2'd3;
    localparam logic [4:0]  RST_MAX_DIGITS = 5'd20;

    // Longest SET value accepted.
    localparam logic [20:0] VALUE_LIMIT = 21'd1048576;

    localparam logic [62:0] INT63_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    // Characters.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // Upper-case command names, first byte in the low bits.
    localparam logic [55:0] NAME_PING   = 56'h0000_0047_4E49_50;
    localparam logic [55:0] NAME_SET    = 56'h0000_0000_5445_53;
    localparam logic [55:0] NAME_GET    = 56'h0000_0000_5445_47;
    localparam logic [55:0] NAME_DEL    = 56'h0000_0000_4C45_44;
    localparam logic [55:0] NAME_EXISTS = 56'h0053_5453_4958_45;
    localparam logic [55:0] NAME_EXPIRE = 56'h0045_5249_5058_45;
    localparam logic [55:0] NAME_TTL    = 56'h0000_0000_4C54_54;

    // Looks up the command from the collected name.
    function automatic logic [2:0] match_cmd(input logic [55:0] name,
                                             input logic [20:0] len);
        logic [2:0] cmd;
        cmd = CMD_NONE;
        if (len == 21'd4 && name == NAME_PING) cmd = CMD_PING;
        if (len == 21'd3 && name == NAME_SET) cmd = CMD_SET;
        if (len == 21'd3 && name == NAME_GET) cmd = CMD_GET;
        if (len == 21'd3 && name == NAME_DEL) cmd = CMD_DEL;
        if (len == 21'd6 && name == NAME_EXISTS) cmd = CMD_EXISTS;
        if (len == 21'd6 && name == NAME_EXPIRE) cmd = CMD_EXPIRE;
        if (len == 21'd3 && name == NAME_TTL) cmd = CMD_TTL;
        return cmd;
    endfunction

    // Number of elements each command takes, name included.
    function automatic logic [1:0] cmd_arity(input logic [2:0] cmd);
        logic [1:0] n;
        case (cmd)
            CMD_PING:   n = 2'd1;
            CMD_SET:    n = 2'd3;
            CMD_EXPIRE: n = 2'd3;
            default:    n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rcp_dec_acc.sv @@
// One step of decimal accumulation with 63-bit overflow detection.
// Uses rcp_pkg for the limit and character codes.
`default_nettype none

module rcp_dec_acc
    import rcp_pkg::*;
(
    input  wire logic [62:0] i_value,
    input  wire logic        i_invalid,
    input  wire logic [7:0]  i_char,
    output logic      [62:0] o_value,
    output logic             o_invalid
);

    logic        is_digit;
    logic [7:0]  digit;
    logic [66:0] prod;

    // Value times ten plus the digit, in a width that cannot wrap.
    assign is_digit = i_char inside {[CH_ZERO:CH_NINE]};
    assign digit    = i_char - CH_ZERO;
    assign prod     = {1'b0, i_value, 3'b000} + {3'b000, i_value, 1'b0}
                    + {59'd0, digit};

    // A non-digit or an overflow marks the number invalid and keeps the value.
    always_comb begin
        o_value   = i_value;
        o_invalid = i_invalid;
        if (!is_digit) begin
            o_invalid = 1'b1;
        end else if (!i_invalid) begin
            if (prod > {4'd0, INT63_MAX}) begin
                o_invalid = 1'b1;
            end else begin
                o_value = prod[62:0];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/resp_command_parser_core.sv @@
// Bytes pass the input register, then the result register; one input word per
// cycle unless the consumer stalls. The header decimal step (multiply by ten, add
// and limit compare) is the longest path between the two registers.
// Reset (i_rst_n low, synchronous) restores default limits and clears the
// parser, including the halt after a framing error.
// Top level of the RESP command parser; uses rcp_pkg, rcp_dec_acc and the
// assertion macros.
`default_nettype none

`include "resp_command_parser_core_assert.svh"

module resp_command_parser_core
    import rcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [2:0]       o_command,
    output logic [2:0]       o_status,
    output logic             o_recoverable,
    output logic [21:0]      o_frame_length,
    output logic [62:0]      o_expire_seconds,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [20:0] i_cfg_data
);

    // Configuration registers.
    logic [20:0] r_max_key;
    logic [20:0] r_max_bulk;
    logic [1:0]  r_max_elem;
    logic [4:0]  r_max_digits;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [5:0]  r_hdr_cnt, n_hdr_cnt;
    logic [62:0] r_hdr_val, n_hdr_val;
    logic        r_hdr_bad, n_hdr_bad;
    logic [1:0]  r_elem_total, n_elem_total;
    logic [1:0]  r_elem_idx, n_elem_idx;
    logic [20:0] r_body_rem, n_body_rem;
    logic [55:0] r_name_buf, n_name_buf;
    logic [20:0] r_name_len, n_name_len;
    logic        r_key_long, n_key_long;
    logic        r_val_long, n_val_long;
    logic [62:0] r_sec_val, n_sec_val;
    logic        r_sec_bad, n_sec_bad;
    logic [21:0] r_frame_cnt, n_frame_cnt;
    logic        r_halted, n_halted;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_payload;
    logic [2:0]  r_command;
    logic [2:0]  r_status;
    logic        r_recoverable;
    logic [21:0] r_frame_len;
    logic [62:0] r_expire;

    // Next result word.
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [7:0]  res_payload;
    logic [2:0]  res_command;
    logic [2:0]  res_status;
    logic        res_recoverable;
    logic [21:0] res_frame_len;
    logic [62:0] res_expire;

    logic        out_free;
    logic        proc;
    logic [62:0] hdr_acc_val, sec_acc_val;
    logic        hdr_acc_bad, sec_acc_bad;

    assign out_free   = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // Decimal steps for header lines and for the EXPIRE seconds body.
    rcp_dec_acc u_hdr_acc (
        .i_value   (r_hdr_val),
        .i_invalid (r_hdr_bad),
        .i_char    (r_in_byte),
        .o_value   (hdr_acc_val),
        .o_invalid (hdr_acc_bad)
    );

    rcp_dec_acc u_sec_acc (
        .i_value   (r_sec_val),
        .i_invalid (r_sec_bad),
        .i_char    (r_in_byte),
        .o_value   (sec_acc_val),
        .o_invalid (sec_acc_bad)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_key    <= RST_MAX_KEY;
            r_max_bulk   <= RST_MAX_BULK;
            r_max_elem   <= RST_MAX_ELEM;
            r_max_digits <= RST_MAX_DIGITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_KEY:    r_max_key    <= i_cfg_data;
                CFG_MAX_BULK:   r_max_bulk   <= i_cfg_data;
                CFG_MAX_ELEM:   r_max_elem   <= i_cfg_data[1:0];
                CFG_MAX_DIGITS: r_max_digits <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: takes a word whenever the stage behind it moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Parser step for the registered byte.
    always_comb begin
        logic [5:0]  cnt1;
        logic [5:0]  cnt2;
        logic        line_bad;
        logic [20:0] pos;
        logic [7:0]  upper;
        logic        do_fatal;
        logic [2:0]  fatal_st;
        logic        do_finish;
        logic [1:0]  fin_total;
        logic [2:0]  fin_cmd;
        logic [2:0]  fin_st;

        cnt1      = r_hdr_cnt + 6'd1;
        cnt2      = r_hdr_cnt + 6'd2;
        line_bad  = r_hdr_bad || (r_hdr_cnt == 6'd0);
        pos       = r_name_len - r_body_rem;
        upper     = (r_in_byte inside {[CH_LOW_A:CH_LOW_Z]}) ? (r_in_byte - CASE_BIT)
                                                            : r_in_byte;
        do_fatal  = 1'b0;
        fatal_st  = ST_MALFORMED;
        do_finish = 1'b0;
        fin_total = r_elem_total;

        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_hdr_val    = r_hdr_val;
        n_hdr_bad    = r_hdr_bad;
        n_elem_total = r_elem_total;
        n_elem_idx   = r_elem_idx;
        n_body_rem   = r_body_rem;
        n_name_buf   = r_name_buf;
        n_name_len   = r_name_len;
        n_key_long   = r_key_long;
        n_val_long   = r_val_long;
        n_sec_val    = r_sec_val;
        n_sec_bad    = r_sec_bad;
        n_frame_cnt  = r_frame_cnt;
        n_halted     = r_halted;

        res_valid       = 1'b0;
        res_kind        = KIND_FRAME;
        res_payload     = 8'd0;
        res_command     = CMD_NONE;
        res_status      = ST_OK;
        res_recoverable = 1'b0;
        res_frame_len   = 22'd0;
        res_expire      = 63'd0;

        if (proc && !r_halted) begin
            n_frame_cnt = r_frame_cnt + 22'd1;
            case (r_phase)
                PH_STAR: begin
                    if (r_in_byte != CH_STAR) do_fatal = 1'b1;
                    else n_phase = PH_AHDR;
                end
                PH_DOLLAR: begin
                    if (r_in_byte != CH_DOLLAR) do_fatal = 1'b1;
                    else n_phase = PH_BHDR;
                end
                PH_AHDR, PH_BHDR: begin
                    if (r_in_byte == CH_CR) begin
                        n_phase = (r_phase == PH_AHDR) ? PH_AHDR_CR : PH_BHDR_CR;
                    end else if (cnt1 > {1'b0, r_max_digits}) begin
                        do_fatal = 1'b1;
                    end else begin
                        n_hdr_cnt = cnt1;
                        n_hdr_val = hdr_acc_val;
                        n_hdr_bad = hdr_acc_bad;
                    end
                end
                PH_AHDR_CR, PH_BHDR_CR: begin
                    if (r_in_byte == CH_LF) begin
                        // Header line complete.
                        n_hdr_cnt = 6'd0;
                        n_hdr_val = 63'd0;
                        n_hdr_bad = 1'b0;
                        if (r_phase == PH_AHDR_CR) begin
                            if (line_bad || r_hdr_val > {61'd0, r_max_elem}) begin
                                do_fatal = 1'b1;
                            end else begin
                                n_elem_total = r_hdr_val[1:0];
                                n_elem_idx   = 2'd0;
                                fin_total    = r_hdr_val[1:0];
                                if (r_hdr_val[1:0] == 2'd0) do_finish = 1'b1;
                                else n_phase = PH_DOLLAR;
                            end
                        end else if (line_bad) begin
                            do_fatal = 1'b1;
                        end else if (r_hdr_val > {42'd0, r_max_bulk}) begin
                            do_fatal = 1'b1;
                            fatal_st = ST_TOO_LARGE;
                        end else begin
                            if (r_elem_idx == 2'd0) begin
                                n_name_len = r_hdr_val[20:0];
                            end else if (r_elem_idx == 2'd1) begin
                                n_key_long = r_hdr_val[20:0] > r_max_key;
                            end else begin
                                n_val_long = r_hdr_val[20:0] > VALUE_LIMIT;
                                n_sec_val  = 63'd0;
                                n_sec_bad  = (r_hdr_val[20:0] == 21'd0);
                            end
                            n_body_rem = r_hdr_val[20:0];
                            n_phase    = (r_hdr_val[20:0] != 21'd0) ? PH_BODY : PH_BODY_CR;
                        end
                    end else if (r_in_byte == CH_CR) begin
                        // The earlier CR becomes content; this one is pending.
                        if (cnt1 > {1'b0, r_max_digits}) begin
                            do_fatal = 1'b1;
                        end else begin
                            n_hdr_cnt = cnt1;
                            n_hdr_bad = 1'b1;
                        end
                    end else begin
                        // The earlier CR and this byte are both content.
                        if (cnt2 > {1'b0, r_max_digits}) begin
                            do_fatal = 1'b1;
                        end else begin
                            n_hdr_cnt = cnt2;
                            n_hdr_bad = 1'b1;
                            n_phase   = (r_phase == PH_AHDR_CR) ? PH_AHDR : PH_BHDR;
                        end
                    end
                end
                PH_BODY: begin
                    if (r_elem_idx == 2'd0) begin
                        if (pos < 21'd7) n_name_buf[pos[2:0]*8 +: 8] = upper;
                    end else if (r_elem_idx == 2'd1) begin
                        res_valid   = 1'b1;
                        res_kind    = KIND_KEY;
                        res_payload = r_in_byte;
                    end else begin
                        n_sec_val   = sec_acc_val;
                        n_sec_bad   = sec_acc_bad;
                        res_valid   = 1'b1;
                        res_kind    = KIND_VALUE;
                        res_payload = r_in_byte;
                    end
                    n_body_rem = r_body_rem - 21'd1;
                    if (r_body_rem == 21'd1) n_phase = PH_BODY_CR;
                end
                PH_BODY_CR: begin
                    if (r_in_byte != CH_CR) do_fatal = 1'b1;
                    else n_phase = PH_BODY_LF;
                end
                PH_BODY_LF: begin
                    if (r_in_byte != CH_LF) begin
                        do_fatal = 1'b1;
                    end else begin
                        n_elem_idx = r_elem_idx + 2'd1;
                        if (r_elem_idx + 2'd1 >= r_elem_total) do_finish = 1'b1;
                        else n_phase = PH_DOLLAR;
                    end
                end
                default: begin
                    do_fatal = 1'b1;
                end
            endcase
        end

        // Frame end: status by priority, then the frame state is cleared.
        fin_cmd = match_cmd(r_name_buf, r_name_len);
        if (fin_cmd == CMD_NONE) fin_st = ST_UNKNOWN;
        else if (fin_total != cmd_arity(fin_cmd)) fin_st = ST_ARITY;
        else if (fin_cmd != CMD_PING && r_key_long) fin_st = ST_TOO_LARGE;
        else if (fin_cmd == CMD_SET && r_val_long) fin_st = ST_TOO_LARGE;
        else if (fin_cmd == CMD_EXPIRE && r_sec_bad) fin_st = ST_BAD_INT;
        else fin_st = ST_OK;

        if (do_finish) begin
            res_valid       = 1'b1;
            res_kind        = KIND_FRAME;
            res_command     = fin_cmd;
            res_status      = fin_st;
            res_recoverable = 1'b1;
            res_frame_len   = n_frame_cnt;
            res_expire      = (fin_st == ST_OK && fin_cmd == CMD_EXPIRE) ? r_sec_val
                                                                           : 63'd0;
            n_phase      = PH_STAR;
            n_hdr_cnt    = 6'd0;
            n_hdr_val    = 63'd0;
            n_hdr_bad    = 1'b0;
            n_elem_total = 2'd0;
            n_elem_idx   = 2'd0;
            n_body_rem   = 21'd0;
            n_name_buf   = 56'd0;
            n_name_len   = 21'd0;
            n_key_long   = 1'b0;
            n_val_long   = 1'b0;
            n_sec_val    = 63'd0;
            n_sec_bad    = 1'b0;
            n_frame_cnt  = 22'd0;
        end

        // Framing error: report once and stop.
        if (do_fatal) begin
            res_valid  = 1'b1;
            res_kind   = KIND_FRAME;
            res_status = fatal_st;
            n_halted   = 1'b1;
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STAR;
            r_hdr_cnt    <= 6'd0;
            r_hdr_val    <= 63'd0;
            r_hdr_bad    <= 1'b0;
            r_elem_total <= 2'd0;
            r_elem_idx   <= 2'd0;
            r_body_rem   <= 21'd0;
            r_name_buf   <= 56'd0;
            r_name_len   <= 21'd0;
            r_key_long   <= 1'b0;
            r_val_long   <= 1'b0;
            r_sec_val    <= 63'd0;
            r_sec_bad    <= 1'b0;
            r_frame_cnt  <= 22'd0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_hdr_val    <= n_hdr_val;
            r_hdr_bad    <= n_hdr_bad;
            r_elem_total <= n_elem_total;
            r_elem_idx   <= n_elem_idx;
            r_body_rem   <= n_body_rem;
            r_name_buf   <= n_name_buf;
            r_name_len   <= n_name_len;
            r_key_long   <= n_key_long;
            r_val_long   <= n_val_long;
            r_sec_val    <= n_sec_val;
            r_sec_bad    <= n_sec_bad;
            r_frame_cnt  <= n_frame_cnt;
            r_halted     <= n_halted;
        end
    end

    // Result register: holds a word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && res_valid;
        end
        if (proc && res_valid) begin
            r_kind        <= res_kind;
            r_payload     <= res_payload;
            r_command     <= res_command;
            r_status      <= res_status;
            r_recoverable <= res_recoverable;
            r_frame_len   <= res_frame_len;
            r_expire      <= res_expire;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_payload_byte   = r_payload;
    assign o_command        = r_command;
    assign o_status         = r_status;
    assign o_recoverable    = r_recoverable;
    assign o_frame_length   = r_frame_len;
    assign o_expire_seconds = r_expire;

    // Once halted and drained, no further word appears.
    `RCP_ASSERT_NEXT(a_halt_silent, i_clk, i_rst_n, r_halted && !r_out_valid, !r_out_valid)

    // A fatal frame word carries no command and no length.
    `RCP_ASSERT_NOW(a_fatal_fields, i_clk, i_rst_n,
        r_out_valid && r_kind == KIND_FRAME && !r_recoverable,
        r_command == CMD_NONE && r_frame_len == 22'd0 && r_expire == 63'd0)

    // Key and value bytes carry no frame information.
    `RCP_ASSERT_NOW(a_byte_fields, i_clk, i_rst_n,
        r_out_valid && r_kind != KIND_FRAME,
        r_status == ST_OK && r_command == CMD_NONE && !r_recoverable)

endmodule

`default_nettype wire

@@ dv/tb_resp_command_parser_core.sv @@
// Self-checking testbench for resp_command_parser_core, the RESP2 request parser.
// Drives framed and broken byte streams and checks every output word against a
// behavioral parser kept here; depends on rcp_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_resp_command_parser_core;
    import rcp_pkg::*;

    typedef logic [7:0] t_bytes[$];

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  pay;
        logic [2:0]  cmd;
        logic [2:0]  st;
        logic        rec;
        logic [21:0] flen;
        logic [62:0] secs;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_command;
    logic [2:0]  o_status;
    logic        o_recoverable;
    logic [21:0] o_frame_length;
    logic [62:0] o_expire_seconds;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [20:0] i_cfg_data;

    resp_command_parser_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_data_byte(i_data_byte),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_kind(o_kind), .o_payload_byte(o_payload_byte), .o_command(o_command),
        .o_status(o_status), .o_recoverable(o_recoverable),
        .o_frame_length(o_frame_length), .o_expire_seconds(o_expire_seconds),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Clock, 4 ns period.
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Command table used by both the stimulus and the expected-word builder.
    string      cmd_name[7] = '{"PING", "SET", "GET", "DEL", "EXISTS", "EXPIRE", "TTL"};
    logic [2:0] cmd_code[7] = '{CMD_PING, CMD_SET, CMD_GET, CMD_DEL, CMD_EXISTS,
                                CMD_EXPIRE, CMD_TTL};
    int         cmd_args[7] = '{1, 3, 2, 2, 2, 3, 2};

    // Limits as the parser currently holds them.
    logic [20:0] lim_key, lim_bulk;
    logic [1:0]  lim_elem;
    logic [4:0]  lim_digits;

    // Parser state tracked by the expected-word builder.
    t_phase      ph;
    int          hdr_cnt;
    logic [63:0] hdr_val;
    bit          hdr_bad;
    int          elem_total, elem_idx;
    logic [20:0] body_left;
    logic [55:0] name_buf;
    logic [20:0] name_len;
    bit          key_long, value_long, secs_bad;
    logic [63:0] secs_val;
    logic [21:0] frame_len;
    bit          halted;

    t_word pending_words[$];
    int    error_count;
    int    bytes_sent;
    int    idle_pct, stall_pct;
    bit    pad_headers;

    function automatic void clear_frame();
        ph = PH_STAR;
        hdr_cnt = 0; hdr_val = '0; hdr_bad = 0;
        elem_total = 0; elem_idx = 0; body_left = '0;
        name_buf = '0; name_len = '0; key_long = 0;
        secs_val = '0; secs_bad = 0; value_long = 0;
        frame_len = '0;
    endfunction

    function automatic void expect_word(logic [1:0] kind, logic [7:0] pay, logic [2:0] cmd,
                                        logic [2:0] st, logic rec, logic [21:0] flen,
                                        logic [62:0] secs);
        t_word w;
        w.kind = kind; w.pay = pay; w.cmd = cmd; w.st = st;
        w.rec = rec; w.flen = flen; w.secs = secs;
        pending_words.push_back(w);
    endfunction

    function automatic void halt_on(logic [2:0] st);
        expect_word(KIND_FRAME, 8'd0, CMD_NONE, st, 1'b0, 22'd0, 63'd0);
        halted = 1;
    endfunction

    // Decimal accumulation that flags non-digits and values beyond 2^63-1.
    function automatic void add_digit(input logic [7:0] c, inout logic [63:0] v,
                                      inout bit bad);
        logic [63:0] d;
        if (c < CH_ZERO || c > CH_NINE) begin
            bad = 1;
            return;
        end
        d = 64'(c - CH_ZERO);
        if (bad) return;
        if (v > (64'(INT63_MAX) - d) / 64'd10) begin
            bad = 1;
            return;
        end
        v = v * 64'd10 + d;
    endfunction

    // Adds one header content byte; returns 0 once the line is too long.
    function automatic bit header_byte(logic [7:0] c);
        hdr_cnt++;
        add_digit(c, hdr_val, hdr_bad);
        return hdr_cnt <= int'(lim_digits);
    endfunction

    function automatic void finish_frame();
        logic [2:0]  cmd;
        logic [2:0]  st;
        logic [63:0] packed_name;
        int          args;
        cmd = CMD_NONE;
        args = 0;
        for (int i = 0; i < 7; i++) begin
            packed_name = '0;
            for (int j = 0; j < cmd_name[i].len(); j++)
                packed_name[8*j +: 8] = cmd_name[i][j];
            if (int'(name_len) == cmd_name[i].len() && {8'd0, name_buf} == packed_name) begin
                cmd = cmd_code[i];
                args = cmd_args[i];
            end
        end
        st = ST_OK;
        if (cmd == CMD_NONE) st = ST_UNKNOWN;
        else if (elem_total != args) st = ST_ARITY;
        else if (cmd != CMD_PING && key_long) st = ST_TOO_LARGE;
        else if (cmd == CMD_SET && value_long) st = ST_TOO_LARGE;
        else if (cmd == CMD_EXPIRE && secs_bad) st = ST_BAD_INT;
        expect_word(KIND_FRAME, 8'd0, cmd, st, 1'b1, frame_len,
                    (st == ST_OK && cmd == CMD_EXPIRE) ? secs_val[62:0] : 63'd0);
        clear_frame();
    endfunction

    // A header line ended with CR LF.
    function automatic void header_done();
        bit          bad;
        logic [63:0] v;
        bad = hdr_bad || hdr_cnt == 0;
        v = hdr_val;
        hdr_cnt = 0; hdr_val = '0; hdr_bad = 0;
        if (ph == PH_AHDR_CR) begin
            if (bad || v > 64'(lim_elem)) begin
                halt_on(ST_MALFORMED);
                return;
            end
            elem_total = int'(v);
            elem_idx = 0;
            if (elem_total == 0) finish_frame();
            else ph = PH_DOLLAR;
            return;
        end
        if (bad) begin
            halt_on(ST_MALFORMED);
            return;
        end
        if (v > 64'(lim_bulk)) begin
            halt_on(ST_TOO_LARGE);
            return;
        end
        if (elem_idx == 0) name_len = v[20:0];
        else if (elem_idx == 1) key_long = v > 64'(lim_key);
        else begin
            value_long = v > 64'(VALUE_LIMIT);
            secs_val = '0;
            secs_bad = (v == 0);
        end
        body_left = v[20:0];
        ph = (body_left != 0) ? PH_BODY : PH_BODY_CR;
    endfunction

    // Advances the tracked parser by one accepted byte and queues its word, if any.
    function automatic void parse_byte(logic [7:0] b);
        logic [20:0] pos;
        logic [7:0]  up;
        if (halted) return;
        frame_len++;
        case (ph)
            PH_STAR: begin
                if (b != CH_STAR) halt_on(ST_MALFORMED);
                else ph = PH_AHDR;
            end
            PH_DOLLAR: begin
                if (b != CH_DOLLAR) halt_on(ST_MALFORMED);
                else ph = PH_BHDR;
            end
            PH_AHDR, PH_BHDR: begin
                if (b == CH_CR) ph = (ph == PH_AHDR) ? PH_AHDR_CR : PH_BHDR_CR;
                else if (!header_byte(b)) halt_on(ST_MALFORMED);
            end
            PH_AHDR_CR, PH_BHDR_CR: begin
                // A CR without LF is header content.
                if (b == CH_LF) header_done();
                else if (!header_byte(CH_CR)) halt_on(ST_MALFORMED);
                else if (b != CH_CR) begin
                    ph = (ph == PH_AHDR_CR) ? PH_AHDR : PH_BHDR;
                    if (!header_byte(b)) halt_on(ST_MALFORMED);
                end
            end
            PH_BODY: begin
                if (elem_idx == 0) begin
                    pos = name_len - body_left;
                    up = (b >= CH_LOW_A && b <= CH_LOW_Z) ? (b ^ CASE_BIT) : b;
                    if (pos < 7) name_buf[8*pos +: 8] = up;
                end else if (elem_idx == 1) begin
                    expect_word(KIND_KEY, b, CMD_NONE, ST_OK, 1'b0, 22'd0, 63'd0);
                end else begin
                    add_digit(b, secs_val, secs_bad);
                    expect_word(KIND_VALUE, b, CMD_NONE, ST_OK, 1'b0, 22'd0, 63'd0);
                end
                body_left--;
                if (body_left == 0) ph = PH_BODY_CR;
            end
            PH_BODY_CR: begin
                if (b != CH_CR) halt_on(ST_MALFORMED);
                else ph = PH_BODY_LF;
            end
            PH_BODY_LF: begin
                if (b != CH_LF) halt_on(ST_MALFORMED);
                else begin
                    elem_idx++;
                    if (elem_idx >= elem_total) finish_frame();
                    else ph = PH_DOLLAR;
                end
            end
            default: halt_on(ST_MALFORMED);
        endcase
    endfunction

    task automatic log_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Compares each accepted output word with the oldest expected one.
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                log_mismatch("output word with nothing expected");
            end else begin
                w = pending_words.pop_front();
                if (o_kind !== w.kind)
                    log_mismatch($sformatf("kind %0d, expected %0d", o_kind, w.kind));
                if (o_payload_byte !== w.pay)
                    log_mismatch($sformatf("payload %0h, expected %0h", o_payload_byte, w.pay));
                if (o_command !== w.cmd)
                    log_mismatch($sformatf("command %0d, expected %0d", o_command, w.cmd));
                if (o_status !== w.st)
                    log_mismatch($sformatf("status %0d, expected %0d", o_status, w.st));
                if (o_recoverable !== w.rec)
                    log_mismatch($sformatf("recoverable %0b, expected %0b",
                                           o_recoverable, w.rec));
                if (o_frame_length !== w.flen)
                    log_mismatch($sformatf("frame length %0d, expected %0d",
                                           o_frame_length, w.flen));
                if (o_expire_seconds !== w.secs)
                    log_mismatch($sformatf("seconds %0d, expected %0d",
                                           o_expire_seconds, w.secs));
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Sends one word; called and returning at a falling edge.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        parse_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits for every expected word plus the pipeline depth.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_KEY:    lim_key = val;
            CFG_MAX_BULK:   lim_bulk = val;
            CFG_MAX_ELEM:   lim_elem = val[1:0];
            CFG_MAX_DIGITS: lim_digits = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [20:0] key, input logic [20:0] bulk,
                              input logic [1:0] elem, input logic [4:0] digits);
        write_reg(CFG_MAX_KEY, key);
        write_reg(CFG_MAX_BULK, bulk);
        write_reg(CFG_MAX_ELEM, 21'(elem));
        write_reg(CFG_MAX_DIGITS, 21'(digits));
    endtask

    function automatic t_bytes text_bytes(input string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic t_bytes noise_bytes(input int n);
        t_bytes q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        return q;
    endfunction

    // Appends a decimal header value, sometimes with leading zeros.
    function automatic void add_header(ref t_bytes q, input longint unsigned v);
        string s;
        int    w;
        s = $sformatf("%0d", v);
        w = s.len();
        if (pad_headers) w = int'(lim_digits);
        else if ($urandom_range(3) == 0 && int'(lim_digits) > w)
            w = $urandom_range(w, int'(lim_digits));
        while (s.len() < w) s = {"0", s};
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        q.push_back(CH_CR);
        q.push_back(CH_LF);
    endfunction

    // Sends a frame declaring n elements: name, key and value as far as n goes.
    task automatic send_frame(input string name, input int n, input t_bytes key,
                              input t_bytes val);
        t_bytes f, body;
        f.push_back(CH_STAR);
        add_header(f, n);
        for (int e = 0; e < n; e++) begin
            body = (e == 0) ? text_bytes(name) : (e == 1) ? key : val;
            f.push_back(CH_DOLLAR);
            add_header(f, body.size());
            foreach (body[i]) f.push_back(body[i]);
            f.push_back(CH_CR);
            f.push_back(CH_LF);
        end
        foreach (f[i]) send_byte(f[i]);
    endtask

    // Longest body that the current limits let through framing.
    function automatic int body_cap();
        int cap;
        cap = int'(lim_bulk);
        if (lim_digits == 1 && cap > 9) cap = 9;
        if (lim_digits == 2 && cap > 99) cap = 99;
        return cap;
    endfunction

    function automatic t_bytes cut(input t_bytes q, input int cap);
        while (q.size() > cap) q.pop_back();
        return q;
    endfunction

    // One well-formed frame with random command, case, arity and content.
    task automatic random_frame();
        int     k, n, cap, kl;
        string  name, s;
        t_bytes key, val;
        cap = body_cap();
        k = $urandom_range(7);
        name = (k < 7) ? cmd_name[k] : (($urandom_range(1) == 0) ? "XGET" : "EXPIRES");
        for (int i = 0; i < name.len(); i++)
            if ($urandom_range(1) == 0) name[i] = name[i] ^ CASE_BIT;
        if (name.len() > cap) name = (cap == 0) ? "" : name.substr(0, cap - 1);
        n = (k < 7) ? cmd_args[k] : $urandom_range(1, 3);
        if ($urandom_range(4) == 0) n = $urandom_range(0, 3);
        if (n > int'(lim_elem)) n = $urandom_range(0, int'(lim_elem));
        kl = (lim_key <= 40) ? $urandom_range(0, int'(lim_key) + 2) : $urandom_range(0, 12);
        key = cut(noise_bytes(kl), cap);
        if (k == 5 && $urandom_range(4) != 0) begin
            case ($urandom_range(3))
                0: s = $sformatf("%0d", $urandom_range(0, 100000));
                1: s = $sformatf("%0d", {$urandom, $urandom});
                2: s = "9223372036854775807";
                default: s = $sformatf("%0d", 64'h7FFF_FFFF_FFFF_FFFF + $urandom_range(1, 9));
            endcase
            if ($urandom_range(7) == 0) s[$urandom_range(0, s.len() - 1)] = "z";
            val = cut(text_bytes(s), cap);
        end else begin
            val = cut(noise_bytes($urandom_range(0, 12)), cap);
        end
        send_frame(name, n, key, val);
    endtask

    task automatic random_traffic(input int nbytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) random_frame();
    endtask

    // Every command, the name case rules and each recoverable status but too large.
    task automatic test_commands();
        t_bytes none, bin_key;
        bin_key = {8'hFF, 8'h00};
        pad_headers = 1;
        send_frame("PING", 1, none, none);
        pad_headers = 0;
        send_frame("set", 3, text_bytes("k1"), noise_bytes(5));
        send_frame("GeT", 2, noise_bytes(3), none);
        send_frame("DEL", 2, text_bytes("a"), none);
        send_frame("exists", 2, none, none);
        send_frame("EXPIRE", 3, text_bytes("k"), text_bytes("100"));
        send_frame("EXPIRE", 3, text_bytes("k"), text_bytes("9223372036854775807"));
        send_frame("expire", 3, text_bytes("k"), text_bytes("9223372036854775808"));
        send_frame("EXPIRE", 3, text_bytes("k"), none);
        send_frame("EXPIRE", 3, text_bytes("k"), text_bytes("12a"));
        send_frame("TTL", 2, bin_key, none);
        send_frame("FOO", 2, text_bytes("x"), none);
        send_frame("EXPIREX", 3, text_bytes("k"), text_bytes("5"));
        send_frame("", 1, none, none);
        send_frame("", 0, none, none);
        send_frame("GET", 3, text_bytes("k"), text_bytes("v"));
        send_frame("PING", 2, text_bytes("k"), none);
        send_frame("SET", 2, text_bytes("k"), none);
    endtask

    // Key length at and just past a small key limit, then the default comes back.
    task automatic test_key_limit();
        t_bytes none;
        write_reg(CFG_MAX_KEY, 21'd4);
        send_frame("GET", 2, noise_bytes(4), none);
        send_frame("SET", 3, noise_bytes(5), text_bytes("v"));
        send_frame("PING", 1, none, none);
        write_reg(CFG_MAX_KEY, RST_MAX_KEY);
    endtask

    // Random frames under a sweep of limits and idling profiles.
    task automatic test_random_limits();
        idle_pct = 0;  stall_pct = 0;
        random_traffic(30);
        set_limits(21'd0, 21'd1048576, 2'd3, 5'd20);
        idle_pct = 54; stall_pct = 0;
        random_traffic(30);
        set_limits(21'd1048576, 21'd9, 2'd2, 5'd1);
        idle_pct = 0;  stall_pct = 54;
        random_traffic(30);
        set_limits(21'd5, 21'd0, 2'd0, 5'd1);
        idle_pct = 10; stall_pct = 10;
        random_traffic(15);
        set_limits(21'd16, 21'd40, 2'd1, 5'd3);
        random_traffic(30);
        set_limits(21'd8, 21'd1048576, 2'd3, 5'd20);
        idle_pct = 0;  stall_pct = 0;
        random_traffic(25);
        idle_pct = 54; stall_pct = 54;
        random_traffic(25);
    endtask

    // Sender holds off until every expected word is out, then resumes.
    task automatic test_hold_off();
        idle_pct = 10; stall_pct = 54;
        random_traffic(25);
        drain();
        random_traffic(25);
    endtask

    // One framing error halts the parser; later bytes must give nothing.
    task automatic test_fatal();
        t_bytes f;
        idle_pct = 10; stall_pct = 10;
        case ($urandom_range(4))
            0: f.push_back(CH_DOLLAR);
            1: begin
                f.push_back(CH_STAR);
                for (int i = 0; i <= int'(lim_digits); i++) f.push_back(CH_ZERO);
            end
            2: f = text_bytes({"*1\r\n$", $sformatf("%0d", lim_bulk + 1), "\r\n"});
            3: f = text_bytes("*1\r\n$1\r\nAB");
            default: f = text_bytes("*1\r1\r\n");
        endcase
        foreach (f[i]) send_byte(f[i]);
        f = noise_bytes(60);
        foreach (f[i]) send_byte(f[i]);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MAX_KEY;
        i_cfg_data = '0;
        error_count = 0;
        bytes_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        pad_headers = 0;
        lim_key = RST_MAX_KEY;
        lim_bulk = RST_MAX_BULK;
        lim_elem = RST_MAX_ELEM;
        lim_digits = RST_MAX_DIGITS;
        halted = 0;
        clear_frame();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_commands();
        test_key_limit();
        test_random_limits();
        test_hold_off();
        test_fatal();

        drain();
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rcp_pkg.sv
rtl/rcp_dec_acc.sv
rtl/resp_command_parser_core.sv
dv/tb_resp_command_parser_core.sv
